[hdl/hppb_pkg.sv]
`timescale 1ns / 1ps
// hppb_pkg: shared constants for the hash partition page buffer
// no dependencies; used by the interfaces, the modulo unit and the top level

package hppb_pkg;

   // default sizing, handed down through top-level parameters
   localparam int MAX_BUCKETS_DEF      = 32;
   localparam int MAX_PAGE_RECORDS_DEF = 16;
   localparam int KEY_BITS_DEF         = 31;

   // fixed field widths
   localparam int BUCKET_W = 5;
   localparam int DRAIN_W  = 5;

   // register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;
   localparam int BCNT_W      = 6;
   localparam int RPP_W       = 5;
   localparam int ROUND_W     = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUCKET_COUNT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORDS_PER_PAGE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUND_NUMBER     = 2'd2;

   // opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   // dividend bits retired per modulo step
   localparam int MOD_DIGIT_BITS = 4;

endpackage

[hdl/hppb_if.sv]
`timescale 1ns / 1ps
// hppb request, response and register-write channel interfaces
// depends on hppb_pkg

interface hppb_req_if #(
   parameter int KEY_BITS = hppb_pkg::KEY_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [KEY_BITS-1:0]          key;
   logic [hppb_pkg::DRAIN_W-1:0] drain_bucket;

   modport source (output valid, opcode, key, drain_bucket, input ready);
   modport sink   (input valid, opcode, key, drain_bucket, output ready);
endinterface

interface hppb_rsp_if #(
   parameter int KEY_BITS = hppb_pkg::KEY_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [hppb_pkg::BUCKET_W-1:0] bucket;
   logic                          emit_valid;
   logic [KEY_BITS-1:0]           out_key;
   logic                          last;

   modport source (output valid, bucket, emit_valid, out_key, last, input ready);
   modport sink   (input valid, bucket, emit_valid, out_key, last, output ready);
endinterface

interface hppb_csr_if;
   logic                             valid;
   logic                             ready;
   logic [hppb_pkg::CSR_INDEX_W-1:0] index;
   logic [hppb_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/hppb_ram.sv]
`timescale 1ns / 1ps
// hppb_ram: generic single-write, single-read ram with registered read data
// no dependencies

module hppb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/hppb_mod_unit.sv]
`timescale 1ns / 1ps
// hppb_mod_unit: iterative remainder of a key by a small divisor, digit per cycle
// depends on hppb_pkg

module hppb_mod_unit #(
   parameter int KEY_BITS    = hppb_pkg::KEY_BITS_DEF,
   parameter int MAX_BUCKETS = hppb_pkg::MAX_BUCKETS_DEF,
   parameter int BKT_W       = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
   parameter int REM_W       = BKT_W + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_BITS-1:0] dividend,
   input  logic [REM_W-1:0]    divisor,
   output logic                done,
   output logic [REM_W-1:0]    remainder
);

   localparam int DIGIT = hppb_pkg::MOD_DIGIT_BITS;
   localparam int STEPS = (KEY_BITS + DIGIT - 1) / DIGIT;
   localparam int DVD_W = STEPS * DIGIT;
   localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [SW-1:0]    step_ff, step_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   always_comb begin
      logic [DVD_W-1:0] d;
      logic [REM_W-1:0] r;
      d       = dvd_ff;
      r       = rem_ff;
      // restoring remainder, one dividend bit per inner pass
      for (int i = 0; i < DIGIT; i++) begin
         r = {r[REM_W-2:0], d[DVD_W-1]};
         d = d << 1;
         if (r >= divisor) begin
            r = r - divisor;
         end
      end
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = DVD_W'(dividend);
         rem_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         dvd_in  = d;
         rem_in  = r;
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[hdl/hash_partition_page_buffer.sv]
`timescale 1ns / 1ps
// hash_partition_page_buffer: hash partitioning with one page buffer per bucket
// depends on hppb_pkg, hppb_if, hppb_ram and hppb_mod_unit
//
// usage
//   req_bus carries one item per valid/ready handshake: an insert of key or a
//   drain of drain_bucket. rsp_bus returns the results of that item in order;
//   last marks the final result of each item. csr_bus writes bucket_count (0),
//   records_per_page (1) and round_number (2); it is always ready, and the user
//   must write it only while no item is in flight; the block does not enforce this.
//   one item is worked on at a time; req_bus.ready is low until its last
//   result is loaded into the output register, and the next item can be
//   accepted in the cycle after that load.
//   insert without flush: after accept come ceil(KEY_BITS/4) steps of the shared
//   modulo unit, its done flag, the page write, then the result, loaded once
//   the output register is free.
//   a flush or a drain passes each key through an address state and then a
//   data state (registered data of the single read port of the page ram into
//   the output stage), and reads the next key only after that one is loaded.
//   drain of an empty page: the result is loaded once the output register is free.
//   reset clears all fill counts and sets the three csr registers to 1; page ram
//   content is not cleared, entries are read only after being written.
//   a stalled receiver holds the output register; the block then waits with
//   its current result and loses nothing. a new item is accepted while the
//   final result of the previous one still sits in the output register.

module hash_partition_page_buffer #(
   parameter int MAX_BUCKETS      = hppb_pkg::MAX_BUCKETS_DEF,
   parameter int MAX_PAGE_RECORDS = hppb_pkg::MAX_PAGE_RECORDS_DEF,
   parameter int KEY_BITS         = hppb_pkg::KEY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hppb_req_if.sink    req_bus,
   hppb_rsp_if.source  rsp_bus,
   hppb_csr_if.sink    csr_bus
);

   localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int REM_W  = BKT_W + 1;
   localparam int FILL_W = $clog2(MAX_PAGE_RECORDS + 1);
   localparam int DEPTH  = MAX_BUCKETS * MAX_PAGE_RECORDS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW     = hppb_pkg::BUCKET_W;
   localparam int DBW    = BKT_W + hppb_pkg::DRAIN_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_PLACE,
      S_SINGLE,
      S_F_READ,
      S_F_DATA
   } state_type;

   // registers
   state_type                     state_ff, state_in;
   logic [hppb_pkg::BCNT_W-1:0]   bcnt_ff, bcnt_in;
   logic [hppb_pkg::RPP_W-1:0]    rpp_ff, rpp_in;
   logic [hppb_pkg::ROUND_W-1:0]  round_ff, round_in;
   logic [FILL_W-1:0]             fill_ff [MAX_BUCKETS];
   logic [FILL_W-1:0]             fill_in [MAX_BUCKETS];
   logic [KEY_BITS-1:0]           key_ff, key_in;
   logic [BKT_W-1:0]              cur_ff, cur_in;
   logic [BW-1:0]                 obkt_ff, obkt_in;
   logic [FILL_W-1:0]             pos_ff, pos_in;
   logic [FILL_W-1:0]             cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                 rsp_bucket_ff, rsp_bucket_in;
   logic                          rsp_emit_ff, rsp_emit_in;
   logic [KEY_BITS-1:0]           rsp_key_ff, rsp_key_in;
   logic                          rsp_last_ff, rsp_last_in;

   // datapath signals
   logic [REM_W-1:0]    eff_buckets;
   logic [FILL_W-1:0]   eff_page;
   logic [6:0]          mask_bits;
   logic [KEY_BITS-1:0] hash_key;
   logic                div_start;
   logic                div_done;
   logic [REM_W-1:0]    div_rem;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [KEY_BITS-1:0] ram_rd_data;
   logic                rsp_free;
   logic                req_take;
   logic [DBW-1:0]      db_wide;
   logic [BKT_W-1:0]    db_idx;
   logic [FILL_W-1:0]   place_pos;
   logic [FILL_W-1:0]   place_cnt;
   logic [FILL_W-1:0]   next_pos;
   logic [BKT_W+BW-1:0] rem_wide;

   // effective bucket count and page size, clamped into range
   always_comb begin
      logic [7:0] b8;
      logic [7:0] p8;
      b8 = 8'(bcnt_ff);
      p8 = 8'(rpp_ff);
      if (b8 == 8'd0) begin
         eff_buckets = REM_W'(1);
      end else if (b8 > 8'(MAX_BUCKETS)) begin
         eff_buckets = REM_W'(MAX_BUCKETS);
      end else begin
         eff_buckets = REM_W'(b8);
      end
      if (p8 == 8'd0) begin
         eff_page = FILL_W'(1);
      end else if (p8 > 8'(MAX_PAGE_RECORDS)) begin
         eff_page = FILL_W'(MAX_PAGE_RECORDS);
      end else begin
         eff_page = FILL_W'(p8);
      end
   end

   // low-bit key mask; widths at or past KEY_BITS keep the whole key
   assign mask_bits = 7'(bcnt_ff) + 7'(round_ff);

   always_comb begin
      for (int i = 0; i < KEY_BITS; i++) begin
         hash_key[i] = req_bus.key[i] & (8'(i) < {1'b0, mask_bits});
      end
   end

   hppb_mod_unit #(
      .KEY_BITS    (KEY_BITS),
      .MAX_BUCKETS (MAX_BUCKETS),
      .BKT_W       (BKT_W),
      .REM_W       (REM_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (hash_key),
      .divisor   (eff_buckets),
      .done      (div_done),
      .remainder (div_rem)
   );

   hppb_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (DEPTH),
      .AW    (ADDR_W)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;
   assign req_take  = req_bus.valid && (state_ff == S_IDLE);
   assign db_wide   = {BKT_W'(0), req_bus.drain_bucket};
   assign db_idx    = db_wide[BKT_W-1:0];
   assign next_pos  = pos_ff + FILL_W'(1);
   assign rem_wide  = {BW'(0), div_rem[BKT_W-1:0]};

   // slot of the new key: a full page keeps its top slot
   always_comb begin
      if (fill_ff[cur_ff] >= FILL_W'(MAX_PAGE_RECORDS)) begin
         place_pos = FILL_W'(MAX_PAGE_RECORDS - 1);
      end else begin
         place_pos = fill_ff[cur_ff];
      end
      place_cnt = place_pos + FILL_W'(1);
   end

   assign ram_wr_addr = ADDR_W'(ADDR_W'(cur_ff) * ADDR_W'(MAX_PAGE_RECORDS))
                        + ADDR_W'(place_pos);
   assign ram_rd_addr = ADDR_W'(ADDR_W'(cur_ff) * ADDR_W'(MAX_PAGE_RECORDS))
                        + ADDR_W'(pos_ff);

   // sequencer and register updates
   always_comb begin
      state_in      = state_ff;
      bcnt_in       = bcnt_ff;
      rpp_in        = rpp_ff;
      round_in      = round_ff;
      fill_in       = fill_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      obkt_in       = obkt_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_emit_in   = rsp_emit_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      // register writes, masked to each register's width
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            hppb_pkg::CSR_BUCKET_COUNT:     bcnt_in  = csr_bus.data[hppb_pkg::BCNT_W-1:0];
            hppb_pkg::CSR_RECORDS_PER_PAGE: rpp_in   = csr_bus.data[hppb_pkg::RPP_W-1:0];
            hppb_pkg::CSR_ROUND_NUMBER:     round_in = csr_bus.data[hppb_pkg::ROUND_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               key_in  = req_bus.key;
               obkt_in = req_bus.drain_bucket;
               if (req_bus.opcode == hppb_pkg::OP_INSERT) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else if ((db_wide < DBW'(MAX_BUCKETS)) &&
                            (fill_ff[db_idx] != '0)) begin
                  // drain of a partial page
                  cur_in           = db_idx;
                  cnt_in           = fill_ff[db_idx];
                  pos_in           = '0;
                  fill_in[db_idx]  = '0;
                  state_in         = S_F_READ;
               end else begin
                  state_in = S_SINGLE;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               cur_in   = div_rem[BKT_W-1:0];
               obkt_in  = rem_wide[BW-1:0];
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            ram_wr_en = 1'b1;
            if (place_cnt >= eff_page) begin
               // page full: flush every held key, the new one last
               cnt_in          = place_cnt;
               pos_in          = '0;
               fill_in[cur_ff] = '0;
               state_in        = S_F_READ;
            end else begin
               fill_in[cur_ff] = place_cnt;
               state_in        = S_SINGLE;
            end
         end
         S_SINGLE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = obkt_ff;
               rsp_emit_in   = 1'b0;
               rsp_key_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_F_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_F_DATA;
         end
         S_F_DATA: begin
            // read data holds until the next read, so a stall just waits here
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = obkt_ff;
               rsp_emit_in   = 1'b1;
               rsp_key_in    = ram_rd_data;
               rsp_last_in   = (next_pos == cnt_ff);
               pos_in        = next_pos;
               state_in      = (next_pos == cnt_ff) ? S_IDLE : S_F_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bcnt_ff      <= hppb_pkg::BCNT_W'(1);
         rpp_ff       <= hppb_pkg::RPP_W'(1);
         round_ff     <= hppb_pkg::ROUND_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_BUCKETS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bcnt_ff      <= bcnt_in;
         rpp_ff       <= rpp_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      obkt_ff       <= obkt_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_emit_ff   <= rsp_emit_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // channel outputs
   assign req_bus.ready      = (state_ff == S_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.bucket     = rsp_bucket_ff;
   assign rsp_bus.emit_valid = rsp_emit_ff;
   assign rsp_bus.out_key    = rsp_key_ff;
   assign rsp_bus.last       = rsp_last_ff;

endmodule

[tb/hash_partition_page_buffer_tb.sv]
`timescale 1ns / 1ps
// hash_partition_page_buffer_tb: self-checking bench for the hash partition page buffer
// depends on hppb_pkg, hppb_if and the hash_partition_page_buffer top level

module hash_partition_page_buffer_tb;

   localparam int KEY_BITS         = hppb_pkg::KEY_BITS_DEF;
   localparam int MAX_BUCKETS      = hppb_pkg::MAX_BUCKETS_DEF;
   localparam int MAX_PAGE_RECORDS = hppb_pkg::MAX_PAGE_RECORDS_DEF;
   localparam int BUCKET_W         = hppb_pkg::BUCKET_W;
   localparam int DRAIN_W          = hppb_pkg::DRAIN_W;
   localparam int CSR_INDEX_W      = hppb_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W       = hppb_pkg::CSR_DATA_W;
   localparam int BCNT_W           = hppb_pkg::BCNT_W;
   localparam int RPP_W            = hppb_pkg::RPP_W;
   localparam int ROUND_W          = hppb_pkg::ROUND_W;

   // index 3 decodes to no register; writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam int SETTLE_CYCLES = 24;    // idle pause before register writes and at the end
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int TIMEOUT_NS    = 2_000_000;

   typedef struct packed {
      logic                opcode;
      logic [KEY_BITS-1:0] key;
      logic [DRAIN_W-1:0]  drain_bucket;
   } part_req_type;

   typedef struct packed {
      logic [BUCKET_W-1:0] bucket;
      logic                emit_valid;
      logic [KEY_BITS-1:0] out_key;
      logic                last;
   } part_rsp_type;

   logic clock;
   logic reset;

   hppb_req_if #(.KEY_BITS(KEY_BITS)) req_bus ();
   hppb_rsp_if #(.KEY_BITS(KEY_BITS)) rsp_bus ();
   hppb_csr_if                        csr_bus ();

   hash_partition_page_buffer #(
      .MAX_BUCKETS     (MAX_BUCKETS),
      .MAX_PAGE_RECORDS(MAX_PAGE_RECORDS),
      .KEY_BITS        (KEY_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // ---------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // bench state
   // ---------------------------------------------------------------------
   part_req_type req_items_q[$];      // items waiting for the driver
   part_rsp_type page_results_q[$];   // results the block still owes, oldest first
   part_req_type cur_item;            // item currently offered on req_bus
   int unsigned  items_queued;
   int unsigned  items_accepted;
   int unsigned  mismatches;
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   logic         hold_start;
   logic         hold_done;
   int unsigned  hold_left;

   // shadow of the register file, as the block sees it
   logic [BCNT_W-1:0]  cfg_bucket_count;
   logic [RPP_W-1:0]   cfg_records_per_page;
   logic [ROUND_W-1:0] cfg_round;

   // shadow of the page buffers
   logic [KEY_BITS-1:0] page_mem [MAX_BUCKETS][MAX_PAGE_RECORDS];
   int unsigned         fill_cnt [MAX_BUCKETS];

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   // out-of-range register values clamp to the legal range
   function automatic int unsigned eff_buckets();
      if (cfg_bucket_count == '0) return 1;
      if (32'(cfg_bucket_count) > MAX_BUCKETS) return MAX_BUCKETS;
      return 32'(cfg_bucket_count);
   endfunction

   function automatic int unsigned eff_page();
      if (cfg_records_per_page == '0) return 1;
      if (32'(cfg_records_per_page) > MAX_PAGE_RECORDS) return MAX_PAGE_RECORDS;
      return 32'(cfg_records_per_page);
   endfunction

   // low (bucket_count + round) bits of the key, whole key once that reaches
   // the key width, then modulo the clamped bucket count; note the raw count
   // sets the mask width
   function automatic logic [BUCKET_W-1:0] map_bucket(input logic [KEY_BITS-1:0] key);
      int unsigned width;
      logic [31:0] low;
      width = 32'(cfg_bucket_count) + 32'(cfg_round);
      low   = {1'b0, key};
      if (width < KEY_BITS) low = low & ((32'd1 << width) - 32'd1);
      low = low % eff_buckets();
      return low[BUCKET_W-1:0];
   endfunction

   function automatic part_rsp_type make_rsp(input logic [BUCKET_W-1:0] b, input logic ev,
                                             input logic [KEY_BITS-1:0] k, input logic lst);
      part_rsp_type r;
      r.bucket     = b;
      r.emit_valid = ev;
      r.out_key    = k;
      r.last       = lst;
      return r;
   endfunction

   // append one expected result at the tail
   task automatic add_expected(input part_rsp_type r);
      page_results_q = {page_results_q, r};
   endtask

   // emit every held key of a page, oldest first, then empty it
   task automatic flush_page(input logic [BUCKET_W-1:0] b);
      int unsigned n;
      n = fill_cnt[b];
      if (n > MAX_PAGE_RECORDS) n = MAX_PAGE_RECORDS;
      for (int unsigned i = 0; i < n; i++)
         add_expected(make_rsp(b, 1'b1, page_mem[b][i], (i + 1 == n)));
      fill_cnt[b] = 0;
   endtask

   task automatic predict_page_results(input part_req_type it);
      logic [BUCKET_W-1:0] b;
      int unsigned f;
      if (it.opcode == hppb_pkg::OP_INSERT) begin
         b = map_bucket(it.key);
         f = fill_cnt[b];
         if (f >= MAX_PAGE_RECORDS) f = MAX_PAGE_RECORDS - 1;
         page_mem[b][f] = it.key;
         fill_cnt[b] = f + 1;
         // a page size lowered under held keys flushes them all with this one
         if (fill_cnt[b] >= eff_page()) flush_page(b);
         else add_expected(make_rsp(b, 1'b0, '0, 1'b1));
      end else begin
         if (fill_cnt[it.drain_bucket] == 0)
            add_expected(make_rsp(it.drain_bucket, 1'b0, '0, 1'b1));
         else
            flush_page(it.drain_bucket);
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // driver: offers queued items, predicts each one as it is accepted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_page_results(cur_item);
            items_accepted++;
         end
         // free to load a new item once the current one is gone
         if (!req_bus.valid || req_bus.ready) begin
            if (req_items_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_item = req_items_q.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.opcode       <= cur_item.opcode;
               req_bus.key          <= cur_item.key;
               req_bus.drain_bucket <= cur_item.drain_bucket;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver hold-off: one long stretch with ready low, so the output
   // register fills and the block backs up into req_bus
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_start && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks each accepted result against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      part_rsp_type got, exp_r;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = make_rsp(rsp_bus.bucket, rsp_bus.emit_valid, rsp_bus.out_key, rsp_bus.last);
            if (page_results_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result bucket %0d emit %0b key %h last %0b",
                                         got.bucket, got.emit_valid, got.out_key, got.last));
            end else begin
               exp_r = page_results_q.pop_front();
               if (got.bucket !== exp_r.bucket || got.emit_valid !== exp_r.emit_valid ||
                   got.out_key !== exp_r.out_key || got.last !== exp_r.last)
                  report_mismatch($sformatf(
                     "exp bucket %0d emit %0b key %h last %0b, got %0d %0b %h %0b",
                     exp_r.bucket, exp_r.emit_valid, exp_r.out_key, exp_r.last,
                     got.bucket, got.emit_valid, got.out_key, got.last));
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_item(input part_req_type it);
      req_items_q = {req_items_q, it};
      items_queued++;
   endtask

   task automatic queue_insert(input logic [KEY_BITS-1:0] k);
      part_req_type it;
      it.opcode       = hppb_pkg::OP_INSERT;
      it.key          = k;
      it.drain_bucket = DRAIN_W'($urandom_range(0, 31));
      queue_item(it);
   endtask

   task automatic queue_drain(input logic [DRAIN_W-1:0] b);
      part_req_type it;
      logic [31:0] r;
      r = $urandom;
      it.opcode       = hppb_pkg::OP_DRAIN;
      it.key          = r[KEY_BITS-1:0];
      it.drain_bucket = b;
      queue_item(it);
   endtask

   // mostly inserts that build pages up, some drains, mostly of live buckets
   function automatic part_req_type random_item();
      part_req_type it;
      logic [31:0] r;
      int unsigned sel;
      r   = $urandom;
      sel = $urandom_range(0, 99);
      it.opcode       = hppb_pkg::OP_INSERT;
      it.drain_bucket = DRAIN_W'($urandom_range(0, 31));
      if (sel < 40)      it.key = r[KEY_BITS-1:0];
      else if (sel < 85) it.key = KEY_BITS'($urandom_range(0, 255));
      else if (sel < 92) it.key = '1;
      else               it.key = '0;
      if ($urandom_range(0, 99) < 15) begin
         it.opcode = hppb_pkg::OP_DRAIN;
         if ($urandom_range(0, 99) < 70)
            it.drain_bucket = DRAIN_W'($urandom_range(0, eff_buckets() - 1));
      end
      return it;
   endfunction

   // wait, on falling edges, until every item is in and every result is out
   task automatic wait_drained();
      @(negedge clock);
      while (items_accepted != items_queued || page_results_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register write; returns on a falling edge
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      unique case (idx)
         hppb_pkg::CSR_BUCKET_COUNT:     cfg_bucket_count     = val[BCNT_W-1:0];
         hppb_pkg::CSR_RECORDS_PER_PAGE: cfg_records_per_page = val[RPP_W-1:0];
         hppb_pkg::CSR_ROUND_NUMBER:     cfg_round            = val[ROUND_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] bc, input logic [CSR_DATA_W-1:0] rpp,
                             input logic [CSR_DATA_W-1:0] rnd);
      write_reg(hppb_pkg::CSR_BUCKET_COUNT, bc);
      write_reg(hppb_pkg::CSR_RECORDS_PER_PAGE, rpp);
      write_reg(hppb_pkg::CSR_ROUND_NUMBER, rnd);
   endtask

   // ---------------------------------------------------------------------
   // timeout
   // ---------------------------------------------------------------------
   initial begin
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      // known values on every input from time zero
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = hppb_pkg::OP_INSERT;
      req_bus.key          = '0;
      req_bus.drain_bucket = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = hppb_pkg::CSR_BUCKET_COUNT;
      csr_bus.data         = '0;
      items_queued         = 0;
      items_accepted       = 0;
      mismatches           = 0;
      hold_start           = 1'b0;
      send_idle_pct        = 10;
      recv_idle_pct        = 52;
      cfg_bucket_count     = BCNT_W'(1);
      cfg_records_per_page = RPP_W'(1);
      cfg_round            = ROUND_W'(1);
      foreach (fill_cnt[i]) fill_cnt[i] = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: one bucket, one key per page
      queue_insert(KEY_BITS'($urandom_range(0, 1000)));
      queue_drain(5'd0);
      wait_drained();

      // whole key hashing, full pages of sixteen, extreme keys
      set_config(6'd32, 6'd16, 6'd31);
      queue_insert('0);
      queue_insert('1);
      queue_insert(31'd32);
      queue_drain(5'd0);              // partial page of two
      queue_drain(5'd31);             // partial page of one
      queue_drain(5'd5);              // empty page
      wait_drained();

      // zero count and zero page size act as one; zero mask width
      set_config(6'd0, 6'd0, 6'd0);
      queue_insert('1);
      queue_drain(5'd0);
      wait_drained();

      // page size lowered while a page holds keys
      set_config(6'd4, 6'd8, 6'd0);
      queue_insert(31'd1);
      queue_insert(31'd5);
      queue_insert(31'd9);
      wait_drained();
      write_reg(hppb_pkg::CSR_RECORDS_PER_PAGE, 6'd2);
      queue_insert(31'd13);           // flushes the three held keys plus this one
      queue_insert(31'd2);            // held in bucket two
      wait_drained();

      // bucket count lowered while a page holds keys: still drainable by name
      write_reg(hppb_pkg::CSR_BUCKET_COUNT, 6'd1);
      queue_insert(31'd3);
      queue_drain(5'd2);
      queue_drain(5'd0);
      wait_drained();

      // counts above the maximum clamp; unmapped index is ignored
      set_config(6'd63, 6'h3F, 6'h3F);
      write_reg(CSR_UNMAPPED, 6'h3F);
      queue_insert('1);
      queue_insert(31'h4000_0007);
      queue_drain(5'd31);
      queue_drain(5'd7);
      wait_drained();

      // mask one bit short of the key width
      set_config(6'd30, 6'd16, 6'd0);
      queue_insert('1);
      queue_drain(5'd3);
      wait_drained();

      // random phases, each under its own register setting
      for (int p = 0; p < 6; p++) begin
         unique case (p)
            // one bucket, sixteen-key flushes
            0: set_config(6'd1, 6'd16, CSR_DATA_W'($urandom_range(0, 63)));
            1: set_config(6'd32, 6'd16, 6'd31);
            2: set_config(CSR_DATA_W'($urandom_range(0, 63)), CSR_DATA_W'($urandom_range(0, 63)),
                          CSR_DATA_W'($urandom_range(0, 63)));
            3: set_config(6'd3, 6'd4, 6'd0);
            4: set_config(CSR_DATA_W'($urandom_range(0, 63)), CSR_DATA_W'($urandom_range(0, 63)),
                          CSR_DATA_W'($urandom_range(0, 63)));
            default: set_config(6'd63, 6'd0, 6'd31);               // every insert flushes alone
         endcase
         // idling pattern: sender light / receiver heavy, then swapped, then none
         if (p == 2) begin
            send_idle_pct = 52;
            recv_idle_pct = 10;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < 26; i++) queue_item(random_item());
         // receiver stops for a long stretch while the sender keeps offering items
         if (p == 0) hold_start = 1'b1;
         wait_drained();
      end

      wait_drained();
      if (page_results_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", page_results_q.size()));
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
